// File: design/sync_length_crc_packet_deframer_defines.svh
// Assertion macros used by the checker of the deframer.
`ifndef SYNC_LENGTH_CRC_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CRC_PACKET_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLCPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/slcpd_pkg.sv
package slcpd_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [15:0] MAX_BODY_LENGTH_RESET = 16'd1024;

  localparam logic [2:0] PH_HUNT1  = 3'd0;
  localparam logic [2:0] PH_HUNT2  = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;
  localparam logic [2:0] PH_CRC_HI = 3'd6;

  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_drop;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic       is_opcode;
    logic       frame_status;
    logic       frame_last;
  } out_t;

  // CRC-16-CCITT over one byte, most significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/sync_length_crc_packet_deframer.sv
// Channel   Direction  Payload                 Accepted when
// in_       input      slcpd_pkg::in_t         in_valid && !in_stall
// out_      output     slcpd_pkg::out_t        out_valid && !out_stall
// cfg_      input      16-bit max_body_length  cfg_wr_en
//
// Each item is parsed in the cycle it is accepted; its result, if any, sits in
// the output register from the next cycle; one item per cycle when not stalled.
// The per-item path is the byte-wise CRC update and the 16-bit length compare.
// in_stall is high only while a result is held by out_stall.
// Reset is synchronous to clk: the parser returns to the sync hunt and the
// maximum body length returns to 1024.
module sync_length_crc_packet_deframer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  slcpd_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output slcpd_pkg::out_t  out_data,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  logic [15:0]     max_len_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [15:0]     body_len_r, body_len_nxt;
  logic [15:0]     seen_r, seen_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;
  logic            out_valid_r;
  slcpd_pkg::out_t out_data_r;
  slcpd_pkg::out_t res;
  logic            res_valid;
  logic            in_acc;
  logic            out_load;
  logic [15:0]     len_full;
  logic [15:0]     seen_inc;
  logic [15:0]     crc_got;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_load  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign len_full = {in_data.rx_byte, body_len_r[7:0]};
  assign seen_inc = seen_r + 16'd1;
  assign crc_got  = {in_data.rx_byte, crc_lo_r};

  always_comb begin
    phase_nxt    = phase_r;
    body_len_nxt = body_len_r;
    seen_nxt     = seen_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    res_valid    = 1'b0;
    res          = '0;
    if (in_data.link_drop) begin
      phase_nxt    = slcpd_pkg::PH_HUNT1;
      body_len_nxt = '0;
      seen_nxt     = '0;
      crc_nxt      = slcpd_pkg::CRC_INIT;
      crc_lo_nxt   = '0;
    end else begin
      case (phase_r)
        slcpd_pkg::PH_HUNT1: begin
          if (in_data.rx_byte == slcpd_pkg::SYNC_FIRST) begin
            phase_nxt = slcpd_pkg::PH_HUNT2;
          end
        end
        slcpd_pkg::PH_HUNT2: begin
          if (in_data.rx_byte == slcpd_pkg::SYNC_SECOND) begin
            phase_nxt = slcpd_pkg::PH_LEN_LO;
          end else if (in_data.rx_byte != slcpd_pkg::SYNC_FIRST) begin
            phase_nxt = slcpd_pkg::PH_HUNT1;
          end
        end
        slcpd_pkg::PH_LEN_LO: begin
          body_len_nxt = {8'h00, in_data.rx_byte};
          phase_nxt    = slcpd_pkg::PH_LEN_HI;
        end
        slcpd_pkg::PH_LEN_HI: begin
          body_len_nxt = len_full;
          if (len_full == 16'd0 || len_full > max_len_r) begin
            phase_nxt = slcpd_pkg::PH_HUNT1;
          end else begin
            seen_nxt  = '0;
            crc_nxt   = slcpd_pkg::CRC_INIT;
            phase_nxt = slcpd_pkg::PH_BODY;
          end
        end
        slcpd_pkg::PH_BODY: begin
          res_valid     = 1'b1;
          res.kind      = slcpd_pkg::KIND_BODY;
          res.body_byte = in_data.rx_byte;
          res.is_opcode = (seen_r == 16'd0);
          crc_nxt       = slcpd_pkg::crc_byte(crc_r, in_data.rx_byte);
          seen_nxt      = seen_inc;
          if (seen_inc >= body_len_r) begin
            phase_nxt = slcpd_pkg::PH_CRC_LO;
          end
        end
        slcpd_pkg::PH_CRC_LO: begin
          crc_lo_nxt = in_data.rx_byte;
          phase_nxt  = slcpd_pkg::PH_CRC_HI;
        end
        slcpd_pkg::PH_CRC_HI: begin
          res_valid        = 1'b1;
          res.kind         = slcpd_pkg::KIND_END;
          res.frame_status = (crc_got != crc_r);
          res.frame_last   = 1'b1;
          phase_nxt        = slcpd_pkg::PH_HUNT1;
        end
        default: begin
          phase_nxt = slcpd_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= slcpd_pkg::MAX_BODY_LENGTH_RESET;
      phase_r     <= slcpd_pkg::PH_HUNT1;
      body_len_r  <= '0;
      seen_r      <= '0;
      crc_r       <= slcpd_pkg::CRC_INIT;
      crc_lo_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r    <= phase_nxt;
        body_len_r <= body_len_nxt;
        seen_r     <= seen_nxt;
        crc_r      <= crc_nxt;
        crc_lo_r   <= crc_lo_nxt;
      end
      if (out_load) begin
        out_valid_r <= in_acc & res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

endmodule

// File: design/slcpd_checker.sv
`include "sync_length_crc_packet_deframer_defines.svh"

module slcpd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input slcpd_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input slcpd_pkg::out_t out_data
);

  `SLCPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `SLCPD_ASSERT_SAME(a_end_fields, clk, rst_n, out_valid && out_data.kind == slcpd_pkg::KIND_END, out_data.frame_last && out_data.body_byte == 8'h00 && !out_data.is_opcode, "end result fields wrong")
  `SLCPD_ASSERT_SAME(a_body_fields, clk, rst_n, out_valid && out_data.kind == slcpd_pkg::KIND_BODY, !out_data.frame_last && !out_data.frame_status, "body result fields wrong")
  `SLCPD_ASSERT_NEXT(a_drop_silent, clk, rst_n, in_valid && !in_stall && in_data.link_drop, !out_valid, "link drop produced a result")

endmodule

bind sync_length_crc_packet_deframer slcpd_checker u_slcpd_checker (.*);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_LIMIT = 100000;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  slcpd_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  slcpd_pkg::out_t out_data;
  logic            cfg_wr_en = 1'b0;
  logic [15:0]     cfg_wr_data = '0;

  sync_length_crc_packet_deframer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  slcpd_pkg::in_t  pending_bytes[$];
  slcpd_pkg::out_t frame_results_due[$];

  logic [15:0] max_len;
  logic [2:0]  phase;
  logic [15:0] body_len;
  logic [15:0] body_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;

  int item_total;
  int items_taken;
  int drops_seen;
  int body_results;
  int frames_ok;
  int frames_bad;
  int fail_count;
  int gap_left;
  int calm_in;
  int stall_left;
  int calm_out;
  slcpd_pkg::out_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15] ^ data[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? slcpd_pkg::CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic void clear_parser();
    phase = slcpd_pkg::PH_HUNT1;
    body_len = '0;
    body_count = '0;
    crc_acc = slcpd_pkg::CRC_INIT;
    crc_lo = '0;
  endfunction

  function automatic void deframe_byte(input slcpd_pkg::in_t item);
    slcpd_pkg::out_t res;
    logic emit;
    res = '0;
    emit = 1'b0;
    if (item.link_drop) begin
      clear_parser();
    end else begin
      case (phase)
        slcpd_pkg::PH_HUNT1: begin
          if (item.rx_byte == slcpd_pkg::SYNC_FIRST) phase = slcpd_pkg::PH_HUNT2;
        end
        slcpd_pkg::PH_HUNT2: begin
          if (item.rx_byte == slcpd_pkg::SYNC_SECOND) phase = slcpd_pkg::PH_LEN_LO;
          else if (item.rx_byte != slcpd_pkg::SYNC_FIRST) phase = slcpd_pkg::PH_HUNT1;
        end
        slcpd_pkg::PH_LEN_LO: begin
          body_len = {8'h00, item.rx_byte};
          phase = slcpd_pkg::PH_LEN_HI;
        end
        slcpd_pkg::PH_LEN_HI: begin
          body_len[15:8] = item.rx_byte;
          if (body_len == 16'd0 || body_len > max_len) begin
            phase = slcpd_pkg::PH_HUNT1;
          end else begin
            body_count = '0;
            crc_acc = slcpd_pkg::CRC_INIT;
            phase = slcpd_pkg::PH_BODY;
          end
        end
        slcpd_pkg::PH_BODY: begin
          res.kind = slcpd_pkg::KIND_BODY;
          res.body_byte = item.rx_byte;
          res.is_opcode = (body_count == 16'd0);
          emit = 1'b1;
          crc_acc = crc_update(crc_acc, item.rx_byte);
          body_count = body_count + 16'd1;
          if (body_count >= body_len) phase = slcpd_pkg::PH_CRC_LO;
        end
        slcpd_pkg::PH_CRC_LO: begin
          crc_lo = item.rx_byte;
          phase = slcpd_pkg::PH_CRC_HI;
        end
        slcpd_pkg::PH_CRC_HI: begin
          res.kind = slcpd_pkg::KIND_END;
          res.frame_status = ({item.rx_byte, crc_lo} != crc_acc);
          res.frame_last = 1'b1;
          emit = 1'b1;
          phase = slcpd_pkg::PH_HUNT1;
        end
        default: begin
          phase = slcpd_pkg::PH_HUNT1;
        end
      endcase
    end
    if (emit) frame_results_due.push_back(res);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic drop);
    pending_bytes.push_back(slcpd_pkg::in_t'{rx_byte: b, link_drop: drop});
    item_total++;
  endfunction

  function automatic void push_header(input logic [15:0] len);
    push_byte(slcpd_pkg::SYNC_FIRST, 1'b0);
    push_byte(slcpd_pkg::SYNC_SECOND, 1'b0);
    push_byte(len[7:0], 1'b0);
    push_byte(len[15:8], 1'b0);
  endfunction

  function automatic void push_frame(input int len, input bit corrupt, input int extra_sync,
                                     input int fill);
    logic [15:0] acc;
    logic [7:0]  b;
    acc = slcpd_pkg::CRC_INIT;
    repeat (extra_sync) push_byte(slcpd_pkg::SYNC_FIRST, 1'b0);
    push_header(len[15:0]);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      acc = crc_update(acc, b);
      push_byte(b, 1'b0);
    end
    if (corrupt) acc = acc ^ (16'h0001 << $urandom_range(0, 15));
    push_byte(acc[7:0], 1'b0);
    push_byte(acc[15:8], 1'b0);
  endfunction

  function automatic void push_truncated(input int len, input int cut);
    push_header(len[15:0]);
    for (int i = 0; i < cut; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic int pick_len();
    int lim;
    if (max_len == 16'd0) return $urandom_range(1, 8);
    lim = (max_len < 16'd24) ? int'(max_len) : 24;
    if ($urandom_range(0, 19) == 0) lim = (max_len < 16'd300) ? int'(max_len) : 300;
    return $urandom_range(1, lim);
  endfunction

  function automatic void random_traffic(input int n);
    int start;
    int r;
    int len;
    start = item_total;
    while (item_total - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_frame(pick_len(), r >= 60, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                   -1);
      end else if (r < 80) begin
        len = pick_len();
        push_truncated(len, $urandom_range(0, len));
      end else if (r < 87) begin
        if (max_len == 16'hFFFF || $urandom_range(0, 1) == 0) push_header(16'd0);
        else push_header(max_len + 16'd1 + 16'($urandom_range(0, 3)));
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_in = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic next_stall();
    int r;
    if (stall_left > 0) begin
      stall_left--;
      return 1'b1;
    end
    if (calm_out > 0) begin
      calm_out--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_out = $urandom_range(30, 100);
    if (r < 75) return 1'b0;
    if (r < 95) stall_left = $urandom_range(0, 2);
    else stall_left = $urandom_range(8, 40);
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s expected %0h, got %0h", name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data);
        items_taken++;
        if (in_data.link_drop) drops_seen++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results_due.size() == 0) begin
          $error("unexpected result: kind %0h byte %0h opcode %0h status %0h last %0h",
                 out_data.kind, out_data.body_byte, out_data.is_opcode,
                 out_data.frame_status, out_data.frame_last);
          fail_count++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("kind", int'(want.kind), int'(out_data.kind));
          check_field("body_byte", int'(want.body_byte), int'(out_data.body_byte));
          check_field("is_opcode", int'(want.is_opcode), int'(out_data.is_opcode));
          check_field("frame_status", int'(want.frame_status), int'(out_data.frame_status));
          check_field("frame_last", int'(want.frame_last), int'(out_data.frame_last));
          if (want.kind == slcpd_pkg::KIND_BODY) body_results++;
          else if (want.frame_status) frames_bad++;
          else frames_ok++;
        end
      end
      out_stall <= next_stall();
    end
  end

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    while ((pending_bytes.size() != 0 || in_valid || frame_results_due.size() != 0)
           && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (frame_results_due.size() != 0) begin
      $error("%0d results still expected", frame_results_due.size());
      fail_count++;
      frame_results_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len = v;
  endtask

  initial begin
    clear_parser();
    max_len = slcpd_pkg::MAX_BODY_LENGTH_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_byte(8'($urandom_range(0, 255)), 1'b1);
    push_frame(1, 1'b0, 1, 0);
    push_byte(slcpd_pkg::SYNC_FIRST, 1'b0);
    push_byte(8'h12, 1'b0);
    push_header(16'd0);
    push_header(slcpd_pkg::MAX_BODY_LENGTH_RESET + 16'd1);
    push_frame(1, 1'b1, 0, 255);
    random_traffic(220);
    settle();

    write_max_len(16'd1);
    push_header(16'd2);
    random_traffic(140);
    settle();

    write_max_len(16'hFFFF);
    random_traffic(200);
    settle();

    write_max_len(16'hFFFE);
    push_header(16'hFFFF);
    random_traffic(60);
    settle();

    write_max_len(16'd0);
    push_frame(1, 1'b0, 0, -1);
    random_traffic(60);
    settle();

    write_max_len(16'($urandom_range(2, 40)));
    random_traffic(220);
    settle();

    $display("Run covered %0d input items, %0d of them link drops, over six length limits.",
             items_taken, drops_seen);
    $display("Checked %0d body bytes and %0d frame ends, %0d of them with a bad CRC.",
             body_results, frames_ok + frames_bad, frames_bad);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
